// ===== rtl/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants of the descending merge sorter.
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_RI   = 6'b000010,
        S_RJ   = 6'b000100,
        S_MRG  = 6'b001000,
        S_ORD  = 6'b010000,
        S_OVAL = 6'b100000
    } t_state;

endpackage

// ===== rtl/dms_ram.sv =====
// ----------------------------------------------------------------------------
// dms_ram
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module dms_ram
    import dms_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_data                    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_data                    o_rdata
);

    t_data r_mem [DEPTH];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/descending_merge_sorter_core.sv =====
// ----------------------------------------------------------------------------
// descending_merge_sorter_core
// Collects a set of signed values, merge-sorts it bottom-up between two
// memories and streams the values out largest first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  input   | in        | i_in_valid / o_in_ready  | i_sample_value, i_set_end
//  output  | out       | o_out_valid / i_out_ready| o_sorted_value, o_run_end,
//          |           |                          | o_dropped_flag
//
// Loading takes one value per cycle. In every merge pass each element then
// goes through the states S_RI, S_RJ and S_MRG, bound by the single read port
// of the source memory, and each result goes through S_ORD and S_OVAL.
// Inputs are refused from the end of a set until its last result transfers.
// Reset is synchronous and active low; memory contents are not cleared.
// A stalled result holds in the memory read register until it transfers.
// ----------------------------------------------------------------------------
module descending_merge_sorter_core
    import dms_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_set_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_run_end,
    output logic               o_dropped_flag
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [SW-1:0] r_w, n_w;
    logic [SW-1:0] r_i, n_i;
    logic [SW-1:0] r_j, n_j;
    logic [SW-1:0] r_k, n_k;
    logic [SW-1:0] r_mid, n_mid;
    logic [SW-1:0] r_hi, n_hi;
    t_data         r_val_i, n_val_i;

    logic [AW-1:0] rd_addr;
    t_data         rd_data0, rd_data1, rd_data;
    logic          we0, we1;
    logic [AW-1:0] waddr0, waddr1;
    t_data         wdata0, wdata1;
    logic          take_i;
    t_data         merge_data;
    logic [SW-1:0] fill_ext;
    logic [SW-1:0] w2;

    function automatic logic [SW-1:0] run_bound(input logic [SW-1:0] base,
                                                input logic [SW-1:0] len,
                                                input logic [SW-1:0] n);
        logic [SW-1:0] sum;
        sum = base + len;
        return (sum > n) ? n : sum;
    endfunction

    dms_ram #(.DEPTH(CAPACITY)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr0),
        .i_wdata (wdata0),
        .i_raddr (rd_addr),
        .o_rdata (rd_data0)
    );

    dms_ram #(.DEPTH(CAPACITY)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_raddr (rd_addr),
        .o_rdata (rd_data1)
    );

    assign rd_data  = r_src ? rd_data1 : rd_data0;
    assign fill_ext = SW'(r_fill);
    assign w2       = r_w << 1;

    // The first run wins if not empty and the second is empty or smaller.
    assign take_i = (r_i < r_mid) &&
                    ((r_j >= r_hi) || ($signed(r_val_i) > $signed(rd_data)));
    assign merge_data = take_i ? r_val_i : rd_data;

    always_comb begin
        case (r_state)
            S_RI:    rd_addr = r_i[AW-1:0];
            S_RJ:    rd_addr = r_j[AW-1:0];
            default: rd_addr = r_k[AW-1:0];
        endcase
    end

    always_comb begin
        we0    = 1'b0;
        waddr0 = r_fill[AW-1:0];
        wdata0 = i_sample_value;
        we1    = 1'b0;
        waddr1 = r_k[AW-1:0];
        wdata1 = merge_data;
        if (r_state == S_LOAD) begin
            we0 = i_in_valid && (r_fill < CAP_C);
        end else if (r_state == S_MRG) begin
            if (r_src) begin
                we0    = 1'b1;
                waddr0 = r_k[AW-1:0];
                wdata0 = merge_data;
            end else begin
                we1 = 1'b1;
            end
        end
    end

    always_comb begin
        logic [CW-1:0] fill_nx;
        logic [SW-1:0] fill_nx_ext;
        n_state = r_state;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_val_i = r_val_i;
        fill_nx = r_fill;
        fill_nx_ext = fill_ext;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_fill < CAP_C) begin
                        fill_nx = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    fill_nx_ext = SW'(fill_nx);
                    n_fill = fill_nx;
                    if (i_set_end) begin
                        n_src = 1'b0;
                        n_k   = '0;
                        if (fill_nx_ext < SW'(2)) begin
                            n_state = S_ORD;
                        end else begin
                            n_w     = SW'(1);
                            n_i     = '0;
                            n_mid   = SW'(1);
                            n_j     = SW'(1);
                            n_hi    = SW'(2);
                            n_state = S_RI;
                        end
                    end
                end
            end
            S_RI: begin
                n_state = S_RJ;
            end
            S_RJ: begin
                n_val_i = rd_data;
                n_state = S_MRG;
            end
            S_MRG: begin
                if (take_i) begin
                    n_i = r_i + SW'(1);
                end else begin
                    n_j = r_j + SW'(1);
                end
                n_k     = r_k + SW'(1);
                n_state = S_RI;
                if (r_k + SW'(1) == r_hi) begin
                    if (r_hi >= fill_ext) begin
                        // Pass complete: the written memory becomes the source.
                        n_src = ~r_src;
                        n_k   = '0;
                        if (w2 >= fill_ext) begin
                            n_state = S_ORD;
                        end else begin
                            n_w   = w2;
                            n_i   = '0;
                            n_mid = run_bound('0, w2, fill_ext);
                            n_j   = run_bound('0, w2, fill_ext);
                            n_hi  = run_bound('0, w2 << 1, fill_ext);
                        end
                    end else begin
                        n_i   = r_hi;
                        n_k   = r_hi;
                        n_mid = run_bound(r_hi, r_w, fill_ext);
                        n_j   = run_bound(r_hi, r_w, fill_ext);
                        n_hi  = run_bound(r_hi, w2, fill_ext);
                    end
                end
            end
            S_ORD: begin
                n_state = S_OVAL;
            end
            S_OVAL: begin
                if (i_out_ready) begin
                    if (o_run_end) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + SW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_val_i <= n_val_i;
    end

    assign o_in_ready     = (r_state == S_LOAD);
    assign o_out_valid    = (r_state == S_OVAL);
    assign o_sorted_value = $signed(rd_data);
    assign o_run_end      = (r_k + SW'(1) == fill_ext);
    assign o_dropped_flag = r_ovf;

endmodule

// ===== rtl/dms_checker.sv =====
// ----------------------------------------------------------------------------
// dms_checker
// Port-level checks of the descending merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module dms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_set_end,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_sorted_value,
    input logic        o_run_end,
    input logic        o_dropped_flag
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sorted_value) && $stable(o_run_end) &&
            $stable(o_dropped_flag))
        else $error("stalled result changed");

    // The block never takes input while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result valid");

    // The transfer that ends a set closes the input.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_set_end |=> !o_in_ready)
        else $error("input still open after end of set");

    // After the last result of a set the block returns to loading.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_run_end |=> !o_out_valid && o_in_ready)
        else $error("no return to loading after last result");

endmodule

bind descending_merge_sorter_core dms_checker u_dms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_set_end      (i_set_end),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sorted_value (o_sorted_value),
    .o_run_end      (o_run_end),
    .o_dropped_flag (o_dropped_flag)
);

// ===== tb/tb_descending_merge_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_descending_merge_sorter_core
// Feeds sets of signed values through the sorter with random gaps on both
// channels and compares every sorted result against a behavioral model of the
// store, its overflow flag and the descending order.
// ----------------------------------------------------------------------------
module tb_descending_merge_sorter_core;
    import dms_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        t_data value;
        logic  run_end;
        logic  dropped;
    } t_sorted_item;

    class sort_scoreboard;
        t_data        held[$];
        logic         overflow;
        t_sorted_item expected[$];
        int           errors;

        function new();
            overflow = 1'b0;
            errors   = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Mirrors the store on every accepted input transfer and, at the end
        // of a set, queues the sorted results.
        function void note_input(t_data value, logic last);
            t_sorted_item item;
            t_data        key;
            int           j;
            if (held.size() < STORE_DEPTH) begin
                held.push_back(value);
            end else begin
                overflow = 1'b1;
            end
            if (!last) begin
                return;
            end
            // Equal values look the same at the output, so any descending
            // order matches the order the merge produces.
            for (int i = 1; i < held.size(); i++) begin
                key = held[i];
                j   = i;
                while (j > 0 && $signed(held[j-1]) < $signed(key)) begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = key;
            end
            foreach (held[k]) begin
                item.value   = held[k];
                item.run_end = (k == held.size() - 1);
                item.dropped = overflow;
                expected.push_back(item);
            end
            held.delete();
            overflow = 1'b0;
        endfunction

        task check_result(t_data value, logic run_end, logic dropped);
            t_sorted_item want;
            if (expected.size() == 0) begin
                report($sformatf("unexpected result value %h", value));
                return;
            end
            want = expected.pop_front();
            if (value !== want.value) begin
                report($sformatf("sorted_value %h, expected %h", value, want.value));
            end
            if (run_end !== want.run_end) begin
                report($sformatf("run_end %b, expected %b (value %h)",
                                 run_end, want.run_end, want.value));
            end
            if (dropped !== want.dropped) begin
                report($sformatf("dropped_flag %b, expected %b (value %h)",
                                 dropped, want.dropped, want.value));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_sample_value;
    logic               i_set_end;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_sorted_value;
    logic               o_run_end;
    logic               o_dropped_flag;

    sort_scoreboard sorted_sb;
    int             send_calm;
    int             recv_calm;
    int             cycle_count = 0;

    // Directed sets: single extremes, a tie, all extremes together,
    // duplicates spread over both halves, and an ascending run.
    int    directed_lengths [6]  = '{1, 1, 2, 5, 7, 4};
    t_data directed_values  [20] = '{
        32'h8000_0000,
        32'h7fff_ffff,
        32'd5, 32'd5,
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
        32'hffff_fffd, 32'd7, 32'd7, 32'hffff_fffd, 32'd0, 32'd7, 32'hffff_fffd,
        32'd1, 32'd2, 32'd3, 32'd4
    };

    descending_merge_sorter_core #(
        .CAPACITY(STORE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_set_end      (i_set_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_run_end      (o_run_end),
        .o_dropped_flag (o_dropped_flag)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly a random wait before each item, with occasional stretches of none.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic t_data draw_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            // A narrow range around zero gives plenty of equal values.
            1, 2:    return t_data'($urandom_range(0, 15) - 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic int draw_set_length(int set_index);
        if (set_index == 0) begin
            return STORE_DEPTH;
        end
        if (set_index == 1) begin
            return STORE_DEPTH + 3;
        end
        case ($urandom_range(0, 9))
            0:       return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            1, 2:    return $urandom_range(13, STORE_DEPTH);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic send_sample(t_data value, logic last);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_set_end      <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sorted_sb.note_input(value, last);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_sb.expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_receiver();
        int stall;
        forever begin
            stall = draw_gap(recv_calm);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sorted_sb.check_result(o_sorted_value, o_run_end, o_dropped_flag);
        end
    endtask

    initial begin
        int    pos;
        int    sent;
        int    set_index;
        int    len;
        logic  all_same;
        t_data same_value;

        sorted_sb      = new();
        send_calm      = 0;
        recv_calm      = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        i_set_end      = 1'b0;
        i_out_ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            run_receiver();
        join_none

        pos = 0;
        foreach (directed_lengths[s]) begin
            for (int k = 0; k < directed_lengths[s]; k++) begin
                send_sample(directed_values[pos], k == directed_lengths[s] - 1);
                pos++;
            end
        end
        hold_until_drained();

        // The first two random sets fill the store exactly and then overrun
        // it, so that the marked transfer itself is dropped.
        sent      = 0;
        set_index = 0;
        while (sent < RANDOM_ITEMS) begin
            len        = draw_set_length(set_index);
            all_same   = ($urandom_range(0, 11) == 0);
            same_value = draw_value();
            for (int k = 0; k < len; k++) begin
                send_sample(all_same ? same_value : draw_value(), k == len - 1);
            end
            sent += len;
            set_index++;
            if ($urandom_range(0, 5) == 0) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sorted_sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
